FILE: design/double_to_decimal_ascii_unit_defines.svh
// Assertion macros used by the checker file of the decimal text unit.
`ifndef DOUBLE_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define DOUBLE_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define D2A_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("d2a check failed");

// Check that a signal holds its value while a request is stalled.
`define D2A_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) \
		(vld && !rdy) |=> $stable(sig)) else $error("d2a stalled request changed");

`endif

FILE: design/d2a_pkg.sv
// Package with types and constants of the decimal text unit.
`timescale 1ns / 1ps
package d2a_pkg;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ERROR = 8'h00;

	localparam int QDEPTH = 2;

	// Exponent codes of binary64.
	localparam logic [10:0] EXP_SPECIAL = 11'h7FF;
	localparam logic [10:0] EXP_BIAS_INT = 11'd1075;
	localparam logic [10:0] EXP_TOO_BIG  = 11'd1086;
	localparam logic [10:0] SUBN_SHIFT   = 11'd1074;
	localparam logic [10:0] SHIFT_GONE   = 11'd117;

	typedef logic [16:0][63:0] pow_tab_t;
	typedef logic [15:0][9:0][63:0] mult_tab_t;

	typedef struct packed {
		logic        err;
		logic        minus;
		logic [63:0] ipart;
		logic [63:0] frac;
	} d2a_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_INT,
		ST_POINT,
		ST_FRAC
	} d2a_state_t;

	function automatic pow_tab_t build_pow10();
		pow_tab_t t;
		t[0] = 64'd1;
		for (int i = 1; i < 17; i++) begin
			t[i] = t[i-1] * 64'd10;
		end
		return t;
	endfunction

	function automatic mult_tab_t build_mult();
		mult_tab_t t;
		pow_tab_t p;
		p = build_pow10();
		for (int i = 0; i < 16; i++) begin
			for (int k = 0; k < 10; k++) begin
				t[i][k] = p[i] * 64'(k);
			end
		end
		return t;
	endfunction

	localparam pow_tab_t  POW10 = build_pow10();
	localparam mult_tab_t MULT10 = build_mult();

endpackage

FILE: design/d2a_if.sv
// Valid/ready channel interfaces for the binary64 input and the character output.
`timescale 1ns / 1ps
interface d2a_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] value_bits;
	modport source (output valid, output value_bits, input ready);
	modport sink (input valid, input value_bits, output ready);
endinterface

interface d2a_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last;
	logic       error;
	modport source (output valid, output out_char, output last, output error, input ready);
	modport sink (input valid, input out_char, input last, input error, output ready);
endinterface

FILE: design/d2a_front.sv
// Front part: splits a binary64 pattern into integer and 0.64 fraction, flags errors.
`timescale 1ns / 1ps
module d2a_front #(
	parameter int FRACTION_DIGITS = 6
) (
	d2a_in_if.sink          in_ch,
	input  logic            q_full,
	output logic            push,
	output d2a_pkg::d2a_item_t item
);
	localparam logic [63:0] LIMIT = d2a_pkg::POW10[FRACTION_DIGITS + 1];

	logic        neg;
	logic [10:0] bexp;
	logic [52:0] mant;
	logic [10:0] ee;
	logic [10:0] sh;
	logic [116:0] wide;
	logic [63:0] ipart;
	logic [63:0] frac;
	logic        err;

	assign in_ch.ready = !q_full;
	assign push = in_ch.valid && !q_full;

	// Decompose exponent and mantissa into fixed point.
	always_comb begin
		neg   = in_ch.value_bits[63];
		bexp  = in_ch.value_bits[62:52];
		mant  = {bexp != 11'd0, in_ch.value_bits[51:0]};
		ee    = bexp - d2a_pkg::EXP_BIAS_INT;
		sh    = (bexp == 11'd0) ? d2a_pkg::SUBN_SHIFT : (d2a_pkg::EXP_BIAS_INT - bexp);
		wide  = {mant, 64'd0} >> sh[6:0];
		ipart = '0;
		frac  = '0;
		err   = 1'b0;
		if (bexp == d2a_pkg::EXP_SPECIAL || bexp >= d2a_pkg::EXP_TOO_BIG) begin
			err = 1'b1;
		end else if (bexp >= d2a_pkg::EXP_BIAS_INT) begin
			ipart = {11'd0, mant} << ee[3:0];
		end else if (sh < d2a_pkg::SHIFT_GONE) begin
			ipart = {11'd0, wide[116:64]};
			frac  = wide[63:0];
		end
		if (ipart >= LIMIT) begin
			err = 1'b1;
		end
		item.err   = err;
		item.minus = neg && (mant != 53'd0);
		item.ipart = ipart;
		item.frac  = frac;
	end
endmodule

FILE: design/d2a_queue.sv
// Two-entry queue between the front and back parts.
`timescale 1ns / 1ps
module d2a_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  d2a_pkg::d2a_item_t wr_item,
	input  logic               pop,
	output d2a_pkg::d2a_item_t rd_item,
	output logic               full,
	output logic               empty
);
	d2a_pkg::d2a_item_t mem_q [d2a_pkg::QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'(d2a_pkg::QDEPTH));
	assign empty   = (count_q == 2'd0);
	assign rd_item = mem_q[rd_ptr_q];

	// Store entries.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// Advance pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule

FILE: design/d2a_back.sv
// Back part: sequencer that emits the characters of one queued number.
`timescale 1ns / 1ps
module d2a_back #(
	parameter int FRACTION_DIGITS = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  d2a_pkg::d2a_item_t q_item,
	output logic               pop,
	d2a_out_if.source          out_ch
);
	localparam logic [3:0] TOP_POS  = 4'(FRACTION_DIGITS);
	localparam logic [3:0] LAST_CNT = 4'(FRACTION_DIGITS - 1);

	d2a_pkg::d2a_state_t state_q, state_d;

	logic        err_q;
	logic        minus_q;
	logic [63:0] ipart_q;
	logic [63:0] frac_q;
	logic [3:0]  pos_q;
	logic [3:0]  cnt_q;
	logic        started_q;
	logic        out_valid_q;
	logic [7:0]  out_char_q;
	logic        out_last_q;
	logic        out_err_q;

	logic        adv;
	logic        emit;
	logic [7:0]  ch;
	logic        ch_last;
	logic        ch_err;
	logic [3:0]  idig;
	logic [67:0] prod;

	assign adv = !out_valid_q || out_ch.ready;
	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_char = out_char_q;
	assign out_ch.last     = out_last_q;
	assign out_ch.error    = out_err_q;

	// Pick the integer digit at the current position and scale the fraction.
	always_comb begin
		idig = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (ipart_q >= d2a_pkg::MULT10[pos_q][k]) begin
				idig = 4'(k);
			end
		end
		prod = ({4'd0, frac_q} << 3) + ({4'd0, frac_q} << 1);
	end

	// Next state and character selection.
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		emit    = 1'b0;
		ch      = d2a_pkg::CH_ZERO;
		ch_last = 1'b0;
		ch_err  = 1'b0;
		case (state_q)
			d2a_pkg::ST_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = d2a_pkg::ST_LOAD;
				end
			end
			d2a_pkg::ST_LOAD: begin
				if (adv) begin
					if (err_q) begin
						emit    = 1'b1;
						ch      = d2a_pkg::CH_ERROR;
						ch_last = 1'b1;
						ch_err  = 1'b1;
						state_d = d2a_pkg::ST_IDLE;
					end else begin
						emit    = minus_q;
						ch      = d2a_pkg::CH_MINUS;
						state_d = d2a_pkg::ST_INT;
					end
				end
			end
			d2a_pkg::ST_INT: begin
				if (adv) begin
					emit = started_q || (idig != 4'd0) || (pos_q == 4'd0);
					ch   = d2a_pkg::CH_ZERO + {4'd0, idig};
					if (pos_q == 4'd0) begin
						state_d = d2a_pkg::ST_POINT;
					end
				end
			end
			d2a_pkg::ST_POINT: begin
				if (adv) begin
					emit    = 1'b1;
					ch      = d2a_pkg::CH_POINT;
					state_d = d2a_pkg::ST_FRAC;
				end
			end
			d2a_pkg::ST_FRAC: begin
				if (adv) begin
					emit    = 1'b1;
					ch      = d2a_pkg::CH_ZERO + {4'd0, prod[67:64]};
					ch_last = (cnt_q == LAST_CNT);
					if (cnt_q == LAST_CNT) begin
						state_d = d2a_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = d2a_pkg::ST_IDLE;
			end
		endcase
	end

	// Hold state and the work registers of the current number.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= d2a_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			pos_q       <= 4'd0;
			cnt_q       <= 4'd0;
			started_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (adv) begin
				out_valid_q <= emit;
			end
			case (state_q)
				d2a_pkg::ST_LOAD: begin
					if (adv) begin
						pos_q     <= TOP_POS;
						started_q <= 1'b0;
					end
				end
				d2a_pkg::ST_INT: begin
					if (adv) begin
						pos_q <= pos_q - 4'd1;
						if (emit) begin
							started_q <= 1'b1;
						end
					end
				end
				d2a_pkg::ST_POINT: begin
					if (adv) begin
						cnt_q <= 4'd0;
					end
				end
				d2a_pkg::ST_FRAC: begin
					if (adv) begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Load the number and update the remainders.
	always_ff @(posedge clk) begin
		if (pop) begin
			err_q   <= q_item.err;
			minus_q <= q_item.minus;
			ipart_q <= q_item.ipart;
			frac_q  <= q_item.frac;
		end else if (adv && state_q == d2a_pkg::ST_INT) begin
			ipart_q <= ipart_q - d2a_pkg::MULT10[pos_q][idig];
		end else if (adv && state_q == d2a_pkg::ST_FRAC) begin
			frac_q <= prod[63:0];
		end
		if (adv && emit) begin
			out_char_q <= ch;
			out_last_q <= ch_last;
			out_err_q  <= ch_err;
		end
	end
endmodule

FILE: design/double_to_decimal_ascii_unit.sv
// Top level: binary64 pattern in, decimal ASCII text out, one character per transfer.
// in_ch carries one 64-bit binary64 pattern per request (valid/ready).
// out_ch returns its text: optional '-', integer digits, '.', FRACTION_DIGITS
// truncated fraction digits; last marks the final character. NaN, infinity
// and integer parts of FRACTION_DIGITS+2 or more digits give one character
// with error and last set.
// The front part decodes a request in the cycle it is accepted and writes
// it to a two-entry queue, so up to two requests wait while text is emitted.
// The back sequencer pops a queued number in idle, loads it and handles the
// sign slot, walks integer positions from the top at one position per cycle
// while out_ch is not stalled (leading zeros give no character), emits '.',
// and then the FRACTION_DIGITS fraction digits; it pops the next number only
// once it is back in idle after the current number.
// An error result or a '-' passes the queue, the idle pop, the load state and
// the output register; the first integer digit follows the sign slot and the
// walk over the leading zero positions (a zero integer part gives one '0').
// A stalled out_ch holds the output register and freezes the sequencer, which
// still pops a number in idle; the front keeps accepting until the queue is full.
// Reset clears the queue, sequencer and output valid; no character is pending.
`timescale 1ns / 1ps
module double_to_decimal_ascii_unit #(
	parameter int FRACTION_DIGITS = 6
) (
	input  logic      clk,
	input  logic      arst_n,
	d2a_in_if.sink    in_ch,
	d2a_out_if.source out_ch
);
	d2a_pkg::d2a_item_t wr_item;
	d2a_pkg::d2a_item_t rd_item;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	d2a_front #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_front (
		.in_ch  (in_ch),
		.q_full (q_full),
		.push   (push),
		.item   (wr_item)
	);

	d2a_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.full    (q_full),
		.empty   (q_empty)
	);

	d2a_back #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (rd_item),
		.pop     (pop),
		.out_ch  (out_ch)
	);
endmodule

FILE: design/d2a_checker.sv
// Port-level checks of the decimal text unit and their binding.
`timescale 1ns / 1ps
`include "double_to_decimal_ascii_unit_defines.svh"
module d2a_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       out_last,
	input logic       out_error
);
	localparam logic [7:0] CH_NINE = 8'h39;

	logic is_digit;
	logic is_mark;

	// Classify the character on the output.
	assign is_digit = (out_char >= d2a_pkg::CH_ZERO) && (out_char <= CH_NINE);
	assign is_mark  = (out_char == d2a_pkg::CH_MINUS) || (out_char == d2a_pkg::CH_POINT);

	// Hold a stalled character.
	`D2A_ASSERT_HOLD(a_hold_char, clk, arst_n, out_valid, out_ready, out_char)

	// An error result always closes its number and carries the error code.
	`D2A_ASSERT(a_err_last, clk, arst_n, (out_valid && out_error) |-> (out_last && out_char == d2a_pkg::CH_ERROR))

	// Normal characters are digits, sign or point.
	`D2A_ASSERT(a_char_set, clk, arst_n, (out_valid && !out_error) |-> (is_digit || is_mark))

	// The final character of a number is a digit unless it is an error.
	`D2A_ASSERT(a_last_digit, clk, arst_n, (out_valid && out_last && !out_error) |-> is_digit)
endmodule

bind double_to_decimal_ascii_unit d2a_checker u_d2a_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_char  (out_ch.out_char),
	.out_last  (out_ch.last),
	.out_error (out_ch.error)
);
